// ----- rtl/flash_ring_log_writer_assert.svh -----
// ----------------------------------------------------------------------------
// Flash ring log writer assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef FLASH_RING_LOG_WRITER_ASSERT_SVH
`define FLASH_RING_LOG_WRITER_ASSERT_SVH

// checked outside reset only
`define FLW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define FLW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/flw_pkg.sv -----
// ----------------------------------------------------------------------------
// Flash ring log writer package
// Geometry constants, codes and item types shared by the writer modules.
// ----------------------------------------------------------------------------
package flw_pkg;

  localparam int unsigned PAGE_BYTES       = 256;
  localparam int unsigned PAGES_PER_SECTOR = 16;
  localparam int unsigned SECTOR_BYTES     = 4096;

  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned WORD_BYTES  = 8;
  localparam int unsigned LANE_W      = $clog2(WORD_BYTES);
  localparam int unsigned PAGE_WORDS  = (PAGE_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int unsigned WORD_IDX_W  = $clog2(PAGE_WORDS);
  localparam int unsigned FILL_W      = $clog2(PAGE_BYTES + 1);
  localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_IDX_W  = 4;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 24;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WORD,
    S_ERASE
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_FIRST,
    CFG_RING_LAST,
    CFG_START_SECTOR,
    CFG_START_PAGE
  } cfg_idx_e;

  typedef enum logic {
    OP_APPEND,
    OP_FLUSH
  } op_e;

  typedef enum logic {
    KIND_PROGRAM,
    KIND_ERASE
  } kind_e;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  flash_address;
    logic [63:0]        word_data;
    logic [TOTAL_W-1:0] erase_total;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
  } ring_cfg_t;

  typedef struct packed {
    logic                  sector_we;
    logic                  page_we;
    logic [ADDR_W-1:0]     sector;
    logic [PAGE_IDX_W-1:0] page;
  } pos_load_t;

endpackage

// ----- rtl/flash_ring_log_writer.sv -----
// ----------------------------------------------------------------------------
// Flash ring log writer
// Collects log bytes into a page and emits program and erase items for a
// ring of flash sectors.
// ----------------------------------------------------------------------------
// An append item is taken whenever the writer is idle and gives no result
// until the page is full. A full page or a flush item holds the input off
// while the page drains: a page buffer read is primed, then one program word
// per cycle goes out while the output is taken (32 words for a 256-byte
// page), plus one erase item when the page closes a sector. Configuration
// writes are registered; writing the start sector or start page also moves
// the write position.

module flash_ring_log_writer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [flw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [flw_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  flw_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output flw_pkg::out_item_t               out_item_o
);

  import flw_pkg::*;

  ring_cfg_t ring_q, ring_d;
  pos_load_t pos_load;

  always_comb begin
    ring_d             = ring_q;
    pos_load.sector_we = 1'b0;
    pos_load.page_we   = 1'b0;
    pos_load.sector    = cfg_data_i[ADDR_W-1:0];
    pos_load.page      = cfg_data_i[PAGE_IDX_W-1:0];
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RING_FIRST:   ring_d.first = cfg_data_i[ADDR_W-1:0];
        CFG_RING_LAST:    ring_d.last  = cfg_data_i[ADDR_W-1:0];
        CFG_START_SECTOR: pos_load.sector_we = 1'b1;
        CFG_START_PAGE:   pos_load.page_we   = 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= '0;
    end else begin
      ring_q <= ring_d;
    end
  end

  flw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ring_i      (ring_q),
    .pos_load_i  (pos_load),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- rtl/flw_page_ram.sv -----
// ----------------------------------------------------------------------------
// Page buffer RAM
// Word-wide synchronous RAM with single byte-lane writes and a registered read.
// ----------------------------------------------------------------------------
module flw_page_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned LANES = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [$clog2(LANES)-1:0] wlane_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [LANES-1:0][7:0]    rdata_o
);

  logic [LANES-1:0][7:0] mem [DEPTH];
  logic [LANES-1:0][7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i][wlane_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/flw_seq.sv -----
// ----------------------------------------------------------------------------
// Flash ring log writer sequencer
// Fills the page buffer, drains pages as program words and steps the ring.
// ----------------------------------------------------------------------------
`include "flash_ring_log_writer_assert.svh"

module flw_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  flw_pkg::ring_cfg_t ring_i,
  input  flw_pkg::pos_load_t pos_load_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  flw_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output flw_pkg::out_item_t out_item_o
);

  import flw_pkg::*;

  state_e                state_q, state_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [WORD_IDX_W-1:0] word_q, word_d;
  logic [PAGE_IDX_W-1:0] page_q, page_d;
  logic [ADDR_W-1:0]     sector_q, sector_d;
  logic [TOTAL_W-1:0]    erase_cnt_q, erase_cnt_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;

  logic                        in_acc;
  logic                        out_free;
  logic                        ram_we;
  logic                        ram_re;
  logic [WORD_IDX_W-1:0]       ram_raddr;
  logic [WORD_BYTES-1:0][7:0]  ram_rdata;
  logic [63:0]                 word_masked;
  logic [ADDR_W-1:0]           base_addr;
  logic                        last_word;
  logic                        page_wrap;
  logic [ADDR_W:0]             sector_step;
  logic [ADDR_W-1:0]           sector_next;
  logic [ADDR_W-1:0]           erase_target;

  flw_page_ram #(
    .DEPTH (PAGE_WORDS),
    .LANES (WORD_BYTES)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[LANE_W +: WORD_IDX_W]),
    .wlane_i (fill_q[LANE_W-1:0]),
    .wdata_i (in_item_i.data_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // bytes at or past the fill read as zero
  always_comb begin
    for (int b = 0; b < WORD_BYTES; b++) begin
      word_masked[8*b +: 8] =
        (FILL_W'({word_q, LANE_W'(b)}) < fill_q) ? ram_rdata[b] : 8'h00;
    end
  end

  assign base_addr = sector_q + (ADDR_W'(page_q) << PAGE_SHIFT)
                   + (ADDR_W'(word_q) << LANE_W);
  assign last_word = (word_q == WORD_IDX_W'(PAGE_WORDS - 1));
  assign page_wrap = ((32'(page_q) + 32'd1) >= PAGES_PER_SECTOR);

  assign sector_step  = {1'b0, sector_q} + (ADDR_W+1)'(SECTOR_BYTES);
  assign sector_next  = (sector_step > {1'b0, ring_i.last}) ? ring_i.first
                                                            : sector_step[ADDR_W-1:0];
  assign erase_target = (sector_q == ring_i.last) ? ring_i.first
                                                  : sector_q + ADDR_W'(SECTOR_BYTES);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    word_d      = word_q;
    page_d      = page_q;
    sector_d    = sector_q;
    erase_cnt_d = erase_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = word_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          word_d = '0;
          if (in_item_i.op == OP_FLUSH) begin
            state_d = S_READ;
          end else begin
            ram_we = 1'b1;
            fill_d = fill_q + 1'b1;
            if (fill_q == FILL_W'(PAGE_BYTES - 1)) begin
              state_d = S_READ;
            end
          end
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_WORD;
      end
      S_WORD: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_item_d.kind          = KIND_PROGRAM;
          out_item_d.flash_address = base_addr;
          out_item_d.word_data     = word_masked;
          out_item_d.erase_total   = erase_cnt_q;
          out_item_d.last          = last_word && !page_wrap;
          if (last_word) begin
            fill_d = '0;
            if (page_wrap) begin
              page_d   = '0;
              sector_d = sector_next;
              state_d  = S_ERASE;
            end else begin
              page_d  = page_q + 1'b1;
              state_d = S_IDLE;
            end
          end else begin
            word_d    = word_q + 1'b1;
            ram_re    = 1'b1;
            ram_raddr = word_q + 1'b1;
          end
        end
      end
      S_ERASE: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_item_d.kind          = KIND_ERASE;
          out_item_d.flash_address = erase_target;
          out_item_d.word_data     = '0;
          out_item_d.erase_total   = erase_cnt_q + 1'b1;
          out_item_d.last          = 1'b1;
          erase_cnt_d              = erase_cnt_q + 1'b1;
          state_d                  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (pos_load_i.sector_we) begin
      sector_d = pos_load_i.sector;
    end
    if (pos_load_i.page_we) begin
      page_d = pos_load_i.page;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      word_q      <= '0;
      page_q      <= '0;
      sector_q    <= '0;
      erase_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      word_q      <= word_d;
      page_q      <= page_d;
      sector_q    <= sector_d;
      erase_cnt_q <= erase_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  `FLW_ASSERT(a_fill_below_page, (state_q == S_IDLE) |-> (fill_q < FILL_W'(PAGE_BYTES)), "page buffer overfilled")
  `FLW_ASSERT(a_erase_is_last, (out_valid_o && out_item_o.kind == KIND_ERASE) |-> out_item_o.last, "erase item not marked last")
  `FLW_ASSERT(a_no_read_idle, ram_re |-> (state_q != S_IDLE), "page read while idle")
  `FLW_ASSERT(a_erase_count, (state_q == S_ERASE && out_free) |=> (erase_cnt_q == $past(erase_cnt_q) + 1'b1), "erase count not stepped")
  `FLW_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result shown in reset")

endmodule

// ----- tb/flash_ring_log_writer_tb.sv -----
// ----------------------------------------------------------------------------
// Flash ring log writer testbench
// Sends append and flush items, predicts the program and erase items
// from a model of the page buffer and ring position, and compares every
// output item in order. Covers page edges, sector and ring wrap, address
// overflow, a long output stall, and random streams over several layouts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module flash_ring_log_writer_tb;
  import flw_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 40;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_item_o;

  flash_ring_log_writer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [ADDR_W-1:0]     ring_first;
  logic [ADDR_W-1:0]     ring_last;
  logic [ADDR_W-1:0]     start_sector;
  logic [PAGE_IDX_W-1:0] start_pg;
  logic [7:0]            page_bytes [PAGE_BYTES];
  int unsigned           fill;
  logic [PAGE_IDX_W-1:0] page_pos;
  logic [ADDR_W-1:0]     sector_pos;
  logic [TOTAL_W-1:0]    erase_count;

  out_item_t   flash_ops_q [$];
  int unsigned mismatches = 0;
  bit          calm = 1'b0;
  int unsigned hold_req = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] any_sector();
    return ADDR_W'($urandom_range(0, 4095)) << 12;
  endfunction

  task automatic note_error(input string msg);
    if (mismatches < 10) $display("ERROR %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic close_sector();
    logic [ADDR_W:0]   next;
    logic [ADDR_W-1:0] target;
    out_item_t         op;
    next = {1'b0, sector_pos} + (ADDR_W + 1)'(SECTOR_BYTES);
    if (next > {1'b0, ring_last}) next = {1'b0, ring_first};
    sector_pos = next[ADDR_W-1:0];
    target = (sector_pos == ring_last) ? ring_first : sector_pos + ADDR_W'(SECTOR_BYTES);
    erase_count++;
    op.kind          = KIND_ERASE;
    op.flash_address = target;
    op.word_data     = '0;
    op.erase_total   = erase_count;
    op.last          = 1'b1;
    flash_ops_q.push_back(op);
  endtask

  task automatic emit_page_ops();
    logic [ADDR_W-1:0] base;
    logic [63:0]       word;
    bit                ends_sector;
    int unsigned       idx;
    out_item_t         op;
    ends_sector = (int'(page_pos) + 1 >= PAGES_PER_SECTOR);
    base = sector_pos + ADDR_W'(page_pos) * ADDR_W'(PAGE_BYTES);
    for (int unsigned w = 0; w < PAGE_WORDS; w++) begin
      word = '0;
      for (int unsigned b = 0; b < WORD_BYTES; b++) begin
        idx = w * WORD_BYTES + b;
        if (idx < fill && idx < PAGE_BYTES) word[8*b +: 8] = page_bytes[idx];
      end
      op.kind          = KIND_PROGRAM;
      op.flash_address = base + ADDR_W'(w * WORD_BYTES);
      op.word_data     = word;
      op.erase_total   = erase_count;
      op.last          = (w == PAGE_WORDS - 1) && !ends_sector;
      flash_ops_q.push_back(op);
    end
    fill = 0;
    if (ends_sector) begin
      page_pos = '0;
      close_sector();
    end else begin
      page_pos = page_pos + 1'b1;
    end
  endtask

  task automatic model_log_item(input in_item_t it);
    if (it.op == OP_FLUSH) begin
      emit_page_ops();
    end else begin
      if (fill < PAGE_BYTES) begin
        page_bytes[fill] = it.data_byte;
        fill++;
      end
      if (fill >= PAGE_BYTES) emit_page_ops();
    end
  endtask

  task automatic model_config(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_RING_FIRST: ring_first = v[ADDR_W-1:0];
      CFG_RING_LAST:  ring_last  = v[ADDR_W-1:0];
      CFG_START_SECTOR: begin
        start_sector = v[ADDR_W-1:0];
        sector_pos   = start_sector;
      end
      CFG_START_PAGE: begin
        start_pg = v[PAGE_IDX_W-1:0];
        page_pos = start_pg;
      end
      default: ;
    endcase
  endtask

  // shared sender: valid stays up across back-to-back items
  task automatic send_item(input op_e op, input logic [7:0] data);
    in_item_t    it;
    int unsigned gap;
    it.op        = op;
    it.data_byte = data;
    gap = pick_gap();
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    model_log_item(it);
  endtask

  task automatic drain_and_idle();
    in_valid_i <= 1'b0;
    while (flash_ops_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    model_config(idx, v);
  endtask

  task automatic load_layout(input logic [ADDR_W-1:0] first, input logic [ADDR_W-1:0] last,
                             input logic [ADDR_W-1:0] sector,
                             input logic [CFG_DATA_W-1:0] page);
    drain_and_idle();
    cfg_write(CFG_RING_FIRST, first);
    cfg_write(CFG_RING_LAST, last);
    cfg_write(CFG_START_SECTOR, sector);
    cfg_write(CFG_START_PAGE, page);
    cfg_we_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (flash_ops_q.size() == 0) begin
        note_error($sformatf("unexpected item: kind %0d addr %h data %h total %h last %0d",
                             out_item_o.kind, out_item_o.flash_address, out_item_o.word_data,
                             out_item_o.erase_total, out_item_o.last));
      end else begin
        want = flash_ops_q.pop_front();
        if (out_item_o.kind !== want.kind || out_item_o.flash_address !== want.flash_address ||
            out_item_o.word_data !== want.word_data ||
            out_item_o.erase_total !== want.erase_total || out_item_o.last !== want.last) begin
          note_error($sformatf(
            "exp kind %0d addr %h data %h total %h last %0d / got %0d %h %h %h %0d",
            want.kind, want.flash_address, want.word_data, want.erase_total, want.last,
            out_item_o.kind, out_item_o.flash_address, out_item_o.word_data,
            out_item_o.erase_total, out_item_o.last));
        end
      end
    end
  end

  // receiver: random ready, with a long hold when asked
  initial begin : drive_ready
    int unsigned n;
    @(posedge clk_i);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_ready_i <= 1'b0;
      end else if (calm || $urandom_range(0, 99) < 70) begin
        n = calm ? 1 : $urandom_range(1, 6);
        out_ready_i <= 1'b1;
      end else begin
        n = pick_gap() + 1;
        out_ready_i <= 1'b0;
      end
      repeat (n) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : watchdog
    int unsigned idle;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle = 0;
    end else begin
      idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("flash_ring_log_writer: mismatch");
        $finish;
      end
    end
  end

  task automatic test_flush_empty();
    load_layout(24'h000000, 24'h00F000, 24'h000000, 24'h000000);
    send_item(OP_FLUSH, 8'h00);
  endtask

  task automatic test_partial_page();
    logic [7:0] pattern [9] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h3C};
    foreach (pattern[i]) send_item(OP_APPEND, pattern[i]);
    send_item(OP_FLUSH, 8'hFF);
  endtask

  task automatic test_sector_close();
    load_layout(24'h000000, 24'h00F000, 24'h003000, 24'h00000F);
    send_item(OP_APPEND, 8'hC3);
    send_item(OP_APPEND, 8'h3C);
    send_item(OP_FLUSH, 8'h00);
  endtask

  task automatic test_ring_wrap();
    // last sector steps back to the first
    load_layout(24'h010000, 24'h012000, 24'h012000, 24'h00000F);
    send_item(OP_FLUSH, 8'h00);
    // stepping onto the last sector erases the first
    load_layout(24'h010000, 24'h012000, 24'h011000, 24'h00000F);
    send_item(OP_FLUSH, 8'h00);
  endtask

  task automatic test_top_of_flash();
    // step past 24 bits wraps to the ring start; upper page bits are dropped
    load_layout(24'h000000, 24'hFFF000, 24'hFFF000, 24'hABC00E);
    send_item(OP_APPEND, 8'h96);
    send_item(OP_FLUSH, 8'h00);
    send_item(OP_FLUSH, 8'h00);
  endtask

  task automatic test_erase_overflow();
    // ring bounds reversed: erase target runs past the top of flash
    load_layout(24'hFFF000, 24'h001000, 24'h001000, 24'h00000F);
    send_item(OP_FLUSH, 8'h00);
  endtask

  task automatic test_backpressure();
    load_layout(24'h020000, 24'h02F000, 24'h02F000, 24'h00000F);
    calm = 1'b1;
    hold_req = HOLD_CYCLES;
    while (hold_req != 0) @(posedge clk_i);
    repeat (3) send_item(OP_APPEND, 8'($urandom_range(0, 255)));
    send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
    repeat (3) send_item(OP_APPEND, 8'($urandom_range(0, 255)));
    send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
    drain_and_idle();
    calm = 1'b0;
  endtask

  task automatic test_random_stream();
    op_e op;
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: load_layout(24'h000000, 24'hFFF000, any_sector(),
                       CFG_DATA_W'($urandom_range(12, 15)));
        1: begin
          start_sector = any_sector();
          load_layout(start_sector, start_sector, start_sector,
                      CFG_DATA_W'($urandom_range(0, 15)));
        end
        2: load_layout(any_sector(), any_sector(), any_sector(),
                       CFG_DATA_W'($urandom_range(10, 15)));
        default: load_layout(24'hFFE000, 24'hFFF000, 24'hFFF000, 24'h00000E);
      endcase
      calm = (seg == 2);
      repeat (25) begin
        op = ($urandom_range(0, 99) < 15) ? OP_FLUSH : OP_APPEND;
        send_item(op, 8'($urandom_range(0, 255)));
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    ring_first   = '0;
    ring_last    = '0;
    start_sector = '0;
    start_pg     = '0;
    fill         = 0;
    page_pos     = '0;
    sector_pos   = '0;
    erase_count  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_flush_empty();
    test_partial_page();
    test_sector_close();
    test_ring_wrap();
    test_top_of_flash();
    test_erase_overflow();
    test_backpressure();
    test_random_stream();

    drain_and_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (flash_ops_q.size() != 0) note_error("expected items left over");
    if (mismatches == 0) begin
      $display("flash_ring_log_writer: match");
    end else begin
      $display("flash_ring_log_writer: mismatch");
    end
    $finish;
  end

endmodule
